### design/qls_pkg.sv
`default_nettype none

package qls_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      overflowed;
  } out_item_t;

endpackage

`default_nettype wire

### design/qls_ram.sv
`default_nettype none

module qls_ram #(
  parameter int DEPTH = qls_pkg::CAPACITY_DEF,
  parameter int WIDTH = qls_pkg::VALUE_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/quicksort_lomuto_sorter_top.sv
// Quicksort sorter with Lomuto partitioning.
//
// Input channel (in_valid / in_stall / in_data): one signed 32-bit value per item.
// Items are stored one per cycle while the block is loading. An item with
// is_last set closes the set and starts an in-place sort; items beyond
// CAPACITY are dropped and flagged. in_stall is high from then until the last
// sorted value has been placed in the output register.
// Sorting runs on one element-store port pair and one signed comparator under
// a small sequencer, with an explicit range stack in a second memory:
//   per range: pop, pivot fetch, a compare for each scanned element, a swap
//   for each element moved forward, the final pivot swap, then the pushes.
//   Roughly N*log2(N) scan steps for N elements.
// Output channel (out_valid / out_stall / out_data): ascending values, each
// read from the store, the final one with end_of_run set, all with overflowed
// set if the set lost items. An output register parts the channel from the
// sequencer: while out_stall is high the held item stays and emission pauses.
// Once the last item is in the output register the block returns to loading.
// Reset (rst_n low, synchronous) clears the fill count, drop flag, stack
// pointer and sequencer; store contents are left undefined.

`default_nettype none

module quicksort_lomuto_sorter_top #(
  parameter int CAPACITY = qls_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire qls_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qls_pkg::out_item_t      out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = 2 * IDX_W;
  localparam int VAL_W = qls_pkg::VALUE_W;

  typedef enum logic [14:0] {
    S_LOAD = 15'h0001,
    S_INIT = 15'h0002,
    S_POP  = 15'h0004,
    S_POPW = 15'h0008,
    S_PIV  = 15'h0010,
    S_CMP  = 15'h0020,
    S_SWPA = 15'h0040,
    S_SWPB = 15'h0080,
    S_FIN  = 15'h0100,
    S_FINA = 15'h0200,
    S_FINB = 15'h0400,
    S_PSHL = 15'h0800,
    S_PSHR = 15'h1000,
    S_EMR  = 15'h2000,
    S_EMW  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] bnd_r, bnd_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [VAL_W-1:0] pivot_r, pivot_nxt;
  logic        [VAL_W-1:0] elem_r, elem_nxt;
  qls_pkg::out_item_t      out_r, out_nxt;

  // element store ports
  logic             e_wr_en, e_rd_en;
  logic [IDX_W-1:0] e_wr_addr, e_rd_addr;
  logic [VAL_W-1:0] e_wr_data, e_q;

  // range stack ports
  logic             s_wr_en, s_rd_en;
  logic [IDX_W-1:0] s_wr_addr, s_rd_addr;
  logic [ENT_W-1:0] s_wr_data, s_q;

  logic             in_take, out_take, scan_more, emit_last;
  logic [IDX_W-1:0] pop_lo, pop_hi;

  qls_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_store (
    .clk     (clk),
    .wr_en   (e_wr_en),
    .wr_addr (e_wr_addr),
    .wr_data (e_wr_data),
    .rd_en   (e_rd_en),
    .rd_addr (e_rd_addr),
    .rd_data (e_q)
  );

  qls_ram #(.DEPTH(CAPACITY), .WIDTH(ENT_W)) u_stack (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (s_q)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pop_lo    = s_q[ENT_W-1:IDX_W];
  assign pop_hi    = s_q[IDX_W-1:0];
  // another element remains left of the pivot after this one
  assign scan_more = (CNT_W'(scan_r) + CNT_W'(1)) < CNT_W'(hi_r);
  assign emit_last = (CNT_W'(k_r) + CNT_W'(1)) == fill_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    scan_nxt      = scan_r;
    bnd_nxt       = bnd_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    elem_nxt      = elem_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_take;

    e_wr_en   = 1'b0;
    e_wr_addr = bnd_r;
    e_wr_data = elem_r;
    e_rd_en   = 1'b0;
    e_rd_addr = scan_r;
    s_wr_en   = 1'b0;
    s_wr_addr = sp_r[IDX_W-1:0];
    s_wr_data = {lo_r, hi_r};
    s_rd_en   = 1'b0;
    s_rd_addr = IDX_W'(sp_r - CNT_W'(1));

    unique case (state_r)
      S_LOAD: begin
        if (in_take) begin
          if (fill_r < CNT_W'(CAPACITY)) begin
            e_wr_en   = 1'b1;
            e_wr_addr = fill_r[IDX_W-1:0];
            e_wr_data = in_data.value;
            fill_nxt  = fill_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // seed the stack with the whole set
        sp_nxt = '0;
        if (fill_r > CNT_W'(1)) begin
          s_wr_en   = 1'b1;
          s_wr_addr = '0;
          s_wr_data = {IDX_W'(0), IDX_W'(fill_r - CNT_W'(1))};
          sp_nxt    = CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMR;
        end else begin
          s_rd_en   = 1'b1;
          sp_nxt    = sp_r - CNT_W'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt = pop_lo;
        hi_nxt = pop_hi;
        if (pop_lo >= pop_hi) begin
          state_nxt = S_POP;
        end else begin
          bnd_nxt   = pop_lo;
          scan_nxt  = pop_lo;
          e_rd_en   = 1'b1;
          e_rd_addr = pop_hi;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pivot_nxt = $signed(e_q);
        e_rd_en   = 1'b1;
        e_rd_addr = scan_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // the shared comparator: element at scan against the pivot
        elem_nxt = e_q;
        if ($signed(e_q) <= pivot_r) begin
          e_rd_en   = 1'b1;
          e_rd_addr = bnd_r;
          state_nxt = S_SWPA;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
          if (scan_more) begin
            e_rd_en   = 1'b1;
            e_rd_addr = scan_r + IDX_W'(1);
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SWPA: begin
        e_wr_en   = 1'b1;
        e_wr_addr = bnd_r;
        e_wr_data = elem_r;
        state_nxt = S_SWPB;
      end
      S_SWPB: begin
        // old boundary element still sits in the read register
        e_wr_en   = 1'b1;
        e_wr_addr = scan_r;
        e_wr_data = e_q;
        bnd_nxt   = bnd_r + IDX_W'(1);
        scan_nxt  = scan_r + IDX_W'(1);
        if (scan_more) begin
          e_rd_en   = 1'b1;
          e_rd_addr = scan_r + IDX_W'(1);
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        e_rd_en   = 1'b1;
        e_rd_addr = bnd_r;
        state_nxt = S_FINA;
      end
      S_FINA: begin
        e_wr_en   = 1'b1;
        e_wr_addr = hi_r;
        e_wr_data = e_q;
        state_nxt = S_FINB;
      end
      S_FINB: begin
        e_wr_en   = 1'b1;
        e_wr_addr = bnd_r;
        e_wr_data = pivot_r;
        state_nxt = S_PSHL;
      end
      S_PSHL: begin
        if ((CNT_W'(bnd_r) >= CNT_W'(lo_r) + CNT_W'(2)) && (sp_r < CNT_W'(CAPACITY))) begin
          s_wr_en   = 1'b1;
          s_wr_data = {lo_r, bnd_r - IDX_W'(1)};
          sp_nxt    = sp_r + CNT_W'(1);
        end
        state_nxt = S_PSHR;
      end
      S_PSHR: begin
        if ((CNT_W'(hi_r) >= CNT_W'(bnd_r) + CNT_W'(2)) && (sp_r < CNT_W'(CAPACITY))) begin
          s_wr_en   = 1'b1;
          s_wr_data = {bnd_r + IDX_W'(1), hi_r};
          sp_nxt    = sp_r + CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_EMR: begin
        e_rd_en   = 1'b1;
        e_rd_addr = k_r;
        state_nxt = S_EMW;
      end
      S_EMW: begin
        // hold the fetched value until the output register frees up
        if (!out_valid_nxt) begin
          out_nxt.sorted_value = $signed(e_q);
          out_nxt.end_of_run   = emit_last;
          out_nxt.overflowed   = drop_r;
          out_valid_nxt        = 1'b1;
          if (emit_last) begin
            fill_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_EMR;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      sp_r        <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      scan_r      <= '0;
      bnd_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      sp_r        <= sp_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      scan_r      <= scan_nxt;
      bnd_r       <= bnd_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pivot_r <= pivot_nxt;
    elem_r  <= elem_nxt;
    out_r   <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(CAPACITY))
    else $error("range stack pointer beyond depth");

  a_last_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.is_last |=> in_stall)
    else $error("input not stalled after last item");

  a_boundary : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (bnd_r <= scan_r) && (scan_r < hi_r))
    else $error("partition boundary passed scan index");
`endif

endmodule

`default_nettype wire
